@@ rtl/dtq_pkg.sv @@
package dtq_pkg;

    localparam int MAX_OUT  = 16;   // expiries emitted per tick at most
    localparam int SLOT_W   = 4;
    localparam int DELAY_W  = 31;
    localparam int TAG_W    = 16;
    localparam int HANDLE_W = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_EXPIRY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_STOPPED     = 2'd1,
        STAT_FULL        = 2'd2,
        STAT_NOT_WAITING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_FREE = 2'd0,
        ST_WAIT = 2'd1,
        ST_GONE = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CALC,
        S_RING,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CC_NONE,
        CC_INSERT,
        CC_CANCEL,
        CC_CLEAR,
        CC_CALC,
        CC_RING,
        CC_FREE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      sel;
    } t_cell_ctl;

    typedef struct packed {
        logic is_free;
        logic is_wait;
        logic hit;
        logic hit_next;
    } t_cell_stat;

    typedef struct packed {
        t_op                 op;
        logic [SLOT_W-1:0]   slot;
        logic [DELAY_W-1:0]  delay;
        logic [TAG_W-1:0]    tag;
    } t_in_item;

    typedef struct packed {
        t_kind               kind;
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    user_tag;
        logic                last;
    } t_out_item;

endpackage

@@ rtl/dtq_cell.sv @@
module dtq_cell #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32,
    parameter int IDX       = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dtq_pkg::t_cell_ctl         i_ctl,
    input  logic [TIME_BITS-1:0]       i_now,
    input  logic [TIME_BITS-1:0]       i_deadline,
    input  logic [dtq_pkg::TAG_W-1:0]  i_tag,
    input  logic [$clog2(SLOTS+1)-1:0] i_k,
    input  logic [$clog2(SLOTS+1)-1:0] i_k_next,
    input  logic [TIME_BITS-1:0]       i_pass_over,
    input  logic [$clog2(SLOTS)-1:0]   i_pass_idx,
    input  logic                       i_pass_vld,
    output logic [TIME_BITS-1:0]       o_pass_over,
    output logic [$clog2(SLOTS)-1:0]   o_pass_idx,
    output logic                       o_pass_vld,
    output dtq_pkg::t_cell_stat        o_stat,
    output logic [dtq_pkg::TAG_W-1:0]  o_tag
);

    localparam int IW = $clog2(SLOTS);
    localparam int KW = $clog2(SLOTS+1);

    dtq_pkg::t_slot_st          r_st;
    logic [TIME_BITS-1:0]       r_deadline;
    logic [dtq_pkg::TAG_W-1:0]  r_tag;
    logic [TIME_BITS-1:0]       r_over;
    logic                       r_exp;
    logic                       r_wexp;
    logic [IW-1:0]              r_wr;
    logic [TIME_BITS-1:0]       r_pass_over;
    logic [IW-1:0]              r_pass_idx;
    logic                       r_pass_vld;

    logic [TIME_BITS-1:0]       calc_over;
    logic                       calc_exp;
    logic                       calc_wexp;
    logic                       beat;

    always_comb begin
        calc_over = i_now - r_deadline;
        // passed when the wrapped distance is below half the time range
        calc_exp  = (r_st != dtq_pkg::ST_FREE) && !calc_over[TIME_BITS-1];
        calc_wexp = calc_exp && (r_st == dtq_pkg::ST_WAIT);
        // a waiting expired key passing by goes out ahead of this one
        beat = r_pass_vld && ((r_pass_over > r_over) ||
               ((r_pass_over == r_over) && (r_pass_idx < IW'(IDX))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= dtq_pkg::ST_FREE;
            r_exp  <= 1'b0;
            r_wexp <= 1'b0;
        end else begin
            case (i_ctl.cmd)
                dtq_pkg::CC_INSERT: begin
                    if (i_ctl.sel) r_st <= dtq_pkg::ST_WAIT;
                end
                dtq_pkg::CC_CANCEL: begin
                    if (i_ctl.sel) r_st <= dtq_pkg::ST_GONE;
                end
                dtq_pkg::CC_CLEAR: begin
                    r_st <= dtq_pkg::ST_FREE;
                end
                dtq_pkg::CC_CALC: begin
                    r_exp  <= calc_exp;
                    r_wexp <= calc_wexp;
                end
                dtq_pkg::CC_FREE: begin
                    // a removed slot is held back only by a waiting key past the budget
                    if (r_exp && ((int'(r_wr) < dtq_pkg::MAX_OUT) ||
                                  (!r_wexp && (int'(r_wr) == dtq_pkg::MAX_OUT))))
                        r_st <= dtq_pkg::ST_FREE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            dtq_pkg::CC_INSERT: begin
                if (i_ctl.sel) begin
                    r_deadline <= i_deadline;
                    r_tag      <= i_tag;
                end
            end
            dtq_pkg::CC_CALC: begin
                r_over      <= calc_over;
                r_pass_over <= calc_over;
                r_pass_idx  <= IW'(IDX);
                r_pass_vld  <= calc_wexp;
                r_wr        <= '0;
            end
            dtq_pkg::CC_RING: begin
                if (beat) r_wr <= r_wr + 1'b1;
                r_pass_over <= i_pass_over;
                r_pass_idx  <= i_pass_idx;
                r_pass_vld  <= i_pass_vld;
            end
            default: ;
        endcase
    end

    assign o_pass_over      = r_pass_over;
    assign o_pass_idx       = r_pass_idx;
    assign o_pass_vld       = r_pass_vld;
    assign o_stat.is_free   = (r_st == dtq_pkg::ST_FREE);
    assign o_stat.is_wait   = (r_st == dtq_pkg::ST_WAIT);
    assign o_stat.hit       = r_wexp && (KW'(r_wr) == i_k);
    assign o_stat.hit_next  = r_wexp && (KW'(r_wr) == i_k_next);
    assign o_tag            = r_tag;

endmodule

@@ rtl/deadline_timer_queue.sv @@
// Deadline timer queue: a tick counter and SLOTS one-shot timers.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one command per
// transaction: insert, cancel, tick or clear. Output channel (o_out_valid /
// i_out_stall / o_out_data) carries replies and expiry events; the last
// result of a command has last set. i_cfg_we writes the enable bit.
// Insert, cancel and clear: one reply, registered once the output register is
// free; the next command is taken while that reply waits, but no command is
// taken before the last one is through.
// Tick: advance time, take each slot's overdue amount, let the keys circulate
// around the ring of slot cells (each cell counts the waiting keys that go
// ahead of it), then emit the expiries one by one and free the released slots.
// A stopped tick or a tick with nothing due gives no result.
// The expiry stream runs at one result per cycle; a stall on the output holds
// the current result and pauses the stream where it is.
// Reset (synchronous, active low) frees all slots, clears time and the
// enable bit; deadlines and tags are not cleared.
module deadline_timer_queue #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtq_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    localparam int IW = $clog2(SLOTS);
    localparam int KW = $clog2(SLOTS+1);

    dtq_pkg::t_state     r_state, n_state;
    dtq_pkg::t_in_item   r_item;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic                r_enable;
    logic [IW-1:0]       r_cnt, n_cnt;
    logic [KW-1:0]       r_k, n_k;
    dtq_pkg::t_out_item  r_out, n_out;
    logic                r_out_valid;

    logic                out_free;
    logic                out_load;
    dtq_pkg::t_cell_cmd  cell_cmd;
    logic [IW-1:0]       sel_idx;
    logic [KW-1:0]       k_next;
    logic [TIME_BITS-1:0] ins_deadline;

    dtq_pkg::t_cell_ctl  ctl      [SLOTS];
    dtq_pkg::t_cell_stat stat     [SLOTS];
    logic [dtq_pkg::TAG_W-1:0] tags [SLOTS];
    logic [TIME_BITS-1:0] pass_over [SLOTS];
    logic [IW-1:0]       pass_idx [SLOTS];
    logic                pass_vld [SLOTS];
    logic [SLOTS-1:0]    wait_vec;

    logic                any_free;
    logic [IW-1:0]       first_free;
    logic                any_hit;
    logic                any_hit_next;
    logic [IW-1:0]       hit_idx;
    logic [dtq_pkg::TAG_W-1:0] hit_tag;

    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall   = (r_state != dtq_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;
    assign k_next       = r_k + 1'b1;
    assign ins_deadline = r_now + TIME_BITS'(r_item.delay);

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign ctl[g].cmd  = cell_cmd;
        assign ctl[g].sel  = (sel_idx == IW'(g));
        assign wait_vec[g] = stat[g].is_wait;

        dtq_cell #(
            .SLOTS     (SLOTS),
            .TIME_BITS (TIME_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[g]),
            .i_now       (r_now),
            .i_deadline  (ins_deadline),
            .i_tag       (r_item.tag),
            .i_k         (r_k),
            .i_k_next    (k_next),
            .i_pass_over (pass_over[(g + SLOTS - 1) % SLOTS]),
            .i_pass_idx  (pass_idx[(g + SLOTS - 1) % SLOTS]),
            .i_pass_vld  (pass_vld[(g + SLOTS - 1) % SLOTS]),
            .o_pass_over (pass_over[g]),
            .o_pass_idx  (pass_idx[g]),
            .o_pass_vld  (pass_vld[g]),
            .o_stat      (stat[g]),
            .o_tag       (tags[g])
        );
    end

    always_comb begin
        any_free     = 1'b0;
        first_free   = '0;
        any_hit      = 1'b0;
        any_hit_next = 1'b0;
        hit_idx      = '0;
        hit_tag      = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (stat[i].is_free) begin
                any_free   = 1'b1;
                first_free = IW'(i);
            end
        end
        // at most one cell matches a given rank
        for (int i = 0; i < SLOTS; i++) begin
            if (stat[i].hit) begin
                any_hit = 1'b1;
                hit_idx = hit_idx | IW'(i);
                hit_tag = hit_tag | tags[i];
            end
            if (stat[i].hit_next) any_hit_next = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_out    = '0;
        out_load = 1'b0;
        cell_cmd = dtq_pkg::CC_NONE;
        sel_idx  = '0;
        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = dtq_pkg::S_EXEC;
            end
            dtq_pkg::S_EXEC: begin
                case (r_item.op)
                    dtq_pkg::OP_INSERT: begin
                        if (out_free) begin
                            out_load     = 1'b1;
                            n_out.kind   = dtq_pkg::KIND_INSERT;
                            n_out.last   = 1'b1;
                            if (!r_enable) begin
                                n_out.status = dtq_pkg::STAT_STOPPED;
                            end else if (!any_free) begin
                                n_out.status = dtq_pkg::STAT_FULL;
                            end else begin
                                n_out.status = dtq_pkg::STAT_OK;
                                n_out.handle = dtq_pkg::HANDLE_W'(first_free);
                                cell_cmd     = dtq_pkg::CC_INSERT;
                                sel_idx      = first_free;
                            end
                            n_state = dtq_pkg::S_IDLE;
                        end
                    end
                    dtq_pkg::OP_CANCEL: begin
                        if (out_free) begin
                            out_load     = 1'b1;
                            n_out.kind   = dtq_pkg::KIND_CANCEL;
                            n_out.last   = 1'b1;
                            n_out.handle = r_item.slot;
                            sel_idx      = IW'(r_item.slot);
                            if (!r_enable) begin
                                n_out.status = dtq_pkg::STAT_STOPPED;
                            end else if ((int'(r_item.slot) >= SLOTS) ||
                                         !wait_vec[IW'(r_item.slot)]) begin
                                n_out.status = dtq_pkg::STAT_NOT_WAITING;
                            end else begin
                                n_out.status = dtq_pkg::STAT_OK;
                                cell_cmd     = dtq_pkg::CC_CANCEL;
                            end
                            n_state = dtq_pkg::S_IDLE;
                        end
                    end
                    dtq_pkg::OP_CLEAR: begin
                        if (out_free) begin
                            out_load     = 1'b1;
                            n_out.kind   = dtq_pkg::KIND_CLEAR;
                            n_out.status = dtq_pkg::STAT_OK;
                            n_out.last   = 1'b1;
                            cell_cmd     = dtq_pkg::CC_CLEAR;
                            n_state      = dtq_pkg::S_IDLE;
                        end
                    end
                    dtq_pkg::OP_TICK: begin
                        if (r_enable) begin
                            n_now   = r_now + 1'b1;
                            n_state = dtq_pkg::S_CALC;
                        end else begin
                            n_state = dtq_pkg::S_IDLE;
                        end
                    end
                    default: n_state = dtq_pkg::S_IDLE;
                endcase
            end
            dtq_pkg::S_CALC: begin
                cell_cmd = dtq_pkg::CC_CALC;
                n_cnt    = '0;
                n_state  = dtq_pkg::S_RING;
            end
            dtq_pkg::S_RING: begin
                cell_cmd = dtq_pkg::CC_RING;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == IW'(SLOTS - 1)) begin
                    n_k     = '0;
                    n_state = dtq_pkg::S_EMIT;
                end
            end
            dtq_pkg::S_EMIT: begin
                if (any_hit && (int'(r_k) < dtq_pkg::MAX_OUT)) begin
                    if (out_free) begin
                        out_load       = 1'b1;
                        n_out.kind     = dtq_pkg::KIND_EXPIRY;
                        n_out.status   = dtq_pkg::STAT_OK;
                        n_out.handle   = dtq_pkg::HANDLE_W'(hit_idx);
                        n_out.user_tag = hit_tag;
                        n_out.last     = !any_hit_next ||
                                         (int'(r_k) == dtq_pkg::MAX_OUT - 1);
                        n_k            = k_next;
                    end
                end else begin
                    // release every expired slot ranked inside the emit budget
                    cell_cmd = dtq_pkg::CC_FREE;
                    n_state  = dtq_pkg::S_IDLE;
                end
            end
            default: n_state = dtq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtq_pkg::S_IDLE;
            r_now       <= '0;
            r_enable    <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            if (i_cfg_we) r_enable <= i_cfg_wdata;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_item <= i_in_data;
        if (out_load) r_out <= n_out;
    end

endmodule

@@ rtl/dtq_checker.sv @@
module dtq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input dtq_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dtq_pkg::t_out_item o_out_data
);

    // held result must stay put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one command in flight: stall the transaction after an accepted one
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second command taken while one is in flight");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind != dtq_pkg::KIND_EXPIRY)
        |-> (o_out_data.user_tag == '0) && o_out_data.last)
        else $error("reply with tag or without last");

    a_exp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == dtq_pkg::KIND_EXPIRY)
        |-> (o_out_data.status == dtq_pkg::STAT_OK))
        else $error("expiry with bad status");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ tb/deadline_timer_queue_checker.sv @@
module deadline_timer_queue_checker #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  dtq_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  dtq_pkg::t_out_item i_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output int                 o_errors,
    output int                 o_pending
);
    import dtq_pkg::*;

    logic        run_enable;
    logic [31:0] now_ticks;
    t_slot_st    slot_st  [SLOTS];
    logic [31:0] slot_dl  [SLOTS];
    logic [15:0] slot_tag [SLOTS];
    t_out_item   reply_q  [$];
    int          err_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic t_out_item reply(input t_kind kind, input t_status status,
                                        input logic [HANDLE_W-1:0] handle,
                                        input logic [TAG_W-1:0] utag, input logic last);
        t_out_item r;
        r.kind     = kind;
        r.status   = status;
        r.handle   = handle;
        r.user_tag = utag;
        r.last     = last;
        return r;
    endfunction

    // Expiry pass of a tick: most overdue first, ties to the lower slot.
    task automatic expire_due();
        int          best;
        int          n;
        logic [31:0] over;
        logic [31:0] best_over;
        bit          done;
        n    = 0;
        done = 1'b0;
        while (!done) begin
            best      = -1;
            best_over = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_st[i] != ST_FREE) begin
                    over = now_ticks - slot_dl[i];
                    if (!over[31] && (best < 0 || over > best_over)) begin
                        best      = i;
                        best_over = over;
                    end
                end
            end
            if (best < 0) begin
                done = 1'b1;
            end else if (slot_st[best] == ST_WAIT && n >= MAX_OUT) begin
                done = 1'b1;
            end else begin
                if (slot_st[best] == ST_WAIT) begin
                    reply_q.push_back(reply(KIND_EXPIRY, STAT_OK, HANDLE_W'(best),
                                            slot_tag[best], 1'b0));
                    n++;
                end
                slot_st[best] = ST_FREE;
            end
        end
        if (n > 0)
            reply_q[$].last = 1'b1;
    endtask

    task automatic model_command(input t_in_item cmd);
        int free_idx;
        free_idx = -1;
        case (cmd.op)
            OP_INSERT: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_st[i] == ST_FREE)
                        free_idx = i;
                if (!run_enable) begin
                    reply_q.push_back(reply(KIND_INSERT, STAT_STOPPED, '0, '0, 1'b1));
                end else if (free_idx < 0) begin
                    reply_q.push_back(reply(KIND_INSERT, STAT_FULL, '0, '0, 1'b1));
                end else begin
                    slot_st[free_idx]  = ST_WAIT;
                    slot_dl[free_idx]  = now_ticks + 32'(cmd.delay);
                    slot_tag[free_idx] = cmd.tag;
                    reply_q.push_back(reply(KIND_INSERT, STAT_OK, HANDLE_W'(free_idx),
                                            '0, 1'b1));
                end
            end
            OP_CANCEL: begin
                if (!run_enable) begin
                    reply_q.push_back(reply(KIND_CANCEL, STAT_STOPPED, cmd.slot, '0, 1'b1));
                end else if (int'(cmd.slot) >= SLOTS || slot_st[cmd.slot] != ST_WAIT) begin
                    reply_q.push_back(reply(KIND_CANCEL, STAT_NOT_WAITING, cmd.slot, '0,
                                            1'b1));
                end else begin
                    slot_st[cmd.slot] = ST_GONE;
                    reply_q.push_back(reply(KIND_CANCEL, STAT_OK, cmd.slot, '0, 1'b1));
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++)
                    slot_st[i] = ST_FREE;
                reply_q.push_back(reply(KIND_CLEAR, STAT_OK, '0, '0, 1'b1));
            end
            default: begin
                // stopped tick holds the counter and gives nothing
                if (run_enable) begin
                    now_ticks = now_ticks + 32'd1;
                    expire_due();
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
                     want_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            run_enable = 1'b0;
            now_ticks  = '0;
            for (int i = 0; i < SLOTS; i++)
                slot_st[i] = ST_FREE;
            reply_q.delete();
        end else begin
            if (i_cfg_we)
                run_enable = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                model_command(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %p", $time,
                             i_out_data);
                    err_count++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("kind", want.kind, i_out_data.kind);
                    check_field("status", want.status, i_out_data.status);
                    check_field("handle", want.handle, i_out_data.handle);
                    check_field("user_tag", want.user_tag, i_out_data.user_tag);
                    check_field("last", want.last, i_out_data.last);
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= reply_q.size();
    end

endmodule

@@ tb/deadline_timer_queue_test.sv @@
module deadline_timer_queue_test;
    import dtq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int IDLE_CYCLES = SLOTS + 3 + MAX_OUT + 8;
    localparam int LIMIT       = 600000;
    localparam int RAND_ITEMS  = 110;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    int errors;
    int pending;
    int items_sent  = 0;
    int cycle_count = 0;
    bit quiet_in    = 1'b0;

    deadline_timer_queue #(
        .SLOTS     (SLOTS),
        .TIME_BITS (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    deadline_timer_queue_checker #(
        .SLOTS (SLOTS)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("deadline_timer_queue_test failed");
        $finish;
    end

    // Receiver back-pressure: mostly short stalls, a few long ones, some quiet stretches.
    initial begin
        int r;
        int len;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                i_out_stall <= 1'b0;
                len = $urandom_range(30, 150);
            end else if (r < 55) begin
                i_out_stall <= 1'b0;
                len = $urandom_range(1, 4);
            end else if (r < 90) begin
                i_out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else if (r < 97) begin
                i_out_stall <= 1'b1;
                len = $urandom_range(4, 12);
            end else begin
                i_out_stall <= 1'b1;
                len = $urandom_range(20, 60);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return DELAY_W'($urandom_range(0, 4));
        else if (r < 90)
            return DELAY_W'($urandom_range(5, 40));
        return DELAY_W'($urandom());
    endfunction

    function automatic t_in_item mk_item(input t_op op, input logic [SLOT_W-1:0] slot,
                                         input logic [DELAY_W-1:0] delay,
                                         input logic [TAG_W-1:0] tag);
        t_in_item it;
        it.op    = op;
        it.slot  = slot;
        it.delay = delay;
        it.tag   = tag;
        return it;
    endfunction

    // Unused fields of cancel, tick and clear carry random bits.
    function automatic t_in_item rnd_item(input t_op op);
        return mk_item(op, SLOT_W'($urandom()), DELAY_W'($urandom()), TAG_W'($urandom()));
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = quiet_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_insert(input logic [DELAY_W-1:0] delay);
        send_item(mk_item(OP_INSERT, SLOT_W'($urandom()), delay, TAG_W'($urandom())));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_enable(input logic value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int r;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stopped after reset; clear still works
        send_insert(DELAY_W'(3));
        send_item(mk_item(OP_CANCEL, 4'hF, '0, '0));
        send_item(rnd_item(OP_TICK));
        send_item(rnd_item(OP_CLEAR));

        set_enable(1'b1);
        send_item(mk_item(OP_INSERT, '0, '0, 16'hFFFF));
        send_item(mk_item(OP_INSERT, 4'hF, {DELAY_W{1'b1}}, '0));
        send_item(mk_item(OP_CANCEL, 4'd1, '0, '0));
        send_item(mk_item(OP_CANCEL, 4'd1, {DELAY_W{1'b1}}, 16'hFFFF));
        for (int k = 2; k < SLOTS; k++)
            send_insert(DELAY_W'((k - 2) % 3));
        send_insert(DELAY_W'(1));                   // queue full
        send_item(rnd_item(OP_TICK));               // overdue by one goes before due now
        send_item(mk_item(OP_CANCEL, 4'd5, '0, '0)); // already expired
        send_item(rnd_item(OP_TICK));

        set_enable(1'b0);
        send_item(mk_item(OP_CANCEL, 4'd1, '0, '0));
        send_insert('0);
        set_enable(1'b1);

        while (items_sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                set_enable(($urandom_range(0, 99) < 80) ? 1'b1 : 1'b0);
            else if (r < 50)
                drain();
            quiet_in = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                n = $urandom_range(3, 10);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        send_insert(pick_delay());
                    else if (r < 70)
                        send_item(rnd_item(OP_CANCEL));
                    else if (r < 95)
                        send_item(rnd_item(OP_TICK));
                    else
                        send_item(rnd_item(OP_CLEAR));
                end
            end else if (r < 65) begin
                // fill every slot, overflow, then release them in a burst
                send_item(rnd_item(OP_CLEAR));
                repeat (SLOTS + 1)
                    send_insert(DELAY_W'($urandom_range(0, 2)));
                repeat (3)
                    send_item(rnd_item(OP_TICK));
            end else if (r < 80) begin
                n = $urandom_range(2, 8);
                repeat (n)
                    send_item(rnd_item(OP_TICK));
            end else begin
                n = $urandom_range(3, 8);
                repeat (n)
                    send_item(rnd_item(t_op'($urandom_range(0, 3))));
            end
        end
        quiet_in = 1'b0;

        drain();
        if (errors == 0 && pending == 0)
            $display("deadline_timer_queue_test passed");
        else
            $display("deadline_timer_queue_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/deadline_timer_queue.sv
rtl/dtq_checker.sv
tb/deadline_timer_queue_checker.sv
tb/deadline_timer_queue_test.sv
